/* design/midi_file_chunk_parser_macros.svh */
// ----------------------------------------------------------------------------
// midi file chunk parser assertion macros
// shared concurrent assertion forms, clocked on aclk, idle in reset
// ----------------------------------------------------------------------------
`ifndef MIDI_FILE_CHUNK_PARSER_MACROS_SVH
`define MIDI_FILE_CHUNK_PARSER_MACROS_SVH

// condition holds at every edge out of reset
`define MFCP_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define MFCP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MFCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/midi_fcp_pkg.sv */
// ----------------------------------------------------------------------------
// midi file chunk parser package
// shared types, codes and constants of the header and chunk parser
// ----------------------------------------------------------------------------
package midi_fcp_pkg;

    localparam logic [31:0] ID_HEADER      = 32'h4d546864;
    localparam logic [31:0] ID_TRACK       = 32'h4d54726b;
    localparam logic [31:0] HDR_LEN        = 32'd6;
    localparam logic [31:0] MIN_FILE_LEN   = 32'd4;
    localparam logic [31:0] MIN_CHUNK_LEN  = 32'd4;
    localparam logic [31:0] NEED_LONG      = 32'd4;
    localparam logic [31:0] NEED_SHORT     = 32'd2;
    localparam logic [31:0] WALK_MIN_LEFT  = 32'd4;
    localparam int          SMPTE_BIT      = 15;

    localparam logic [7:0]  SMPTE_24       = 8'd232;
    localparam logic [7:0]  SMPTE_25       = 8'd231;
    localparam logic [7:0]  SMPTE_29       = 8'd227;
    localparam logic [7:0]  SMPTE_30       = 8'd226;

    localparam int          FIFO_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_TRACK  = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_BAD_LEN  = 3'd1,
        STATUS_BAD_FMT  = 3'd2,
        STATUS_BAD_NTRK = 3'd3,
        STATUS_PAST_END = 3'd4
    } status_t;

    typedef enum logic [9:0] {
        PH_IDLE      = 10'b0000000001,
        PH_HDR_ID    = 10'b0000000010,
        PH_HDR_LEN   = 10'b0000000100,
        PH_FMT       = 10'b0000001000,
        PH_NTRK      = 10'b0000010000,
        PH_DIV       = 10'b0000100000,
        PH_CHUNK_ID  = 10'b0001000000,
        PH_CHUNK_LEN = 10'b0010000000,
        PH_SKIP      = 10'b0100000000,
        PH_DONE      = 10'b1000000000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic        file_format;
        logic [14:0] ticks_per_quarter;
        logic [15:0] track_index;
        logic [31:0] data_offset;
        logic [31:0] data_length;
        logic [15:0] tracks_found;
        status_t     status;
        logic        last;
    } result_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  field_count;
        logic [31:0] accumulator;
        logic [31:0] position;
        logic [31:0] skip_left;
        logic        header_format;
        logic [15:0] track_counter;
    } state_t;

    // results raised by one beat, in delivery order
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic logic [4:0] smpte_fps(input logic [7:0] code);
        logic [4:0] fps;
        case (code)
            SMPTE_24: fps = 5'd24;
            SMPTE_25: fps = 5'd25;
            SMPTE_29: fps = 5'd29;
            SMPTE_30: fps = 5'd30;
            default:  fps = 5'd0;
        endcase
        return fps;
    endfunction

endpackage

/* design/midi_file_chunk_parser.sv */
// ----------------------------------------------------------------------------
// midi file chunk parser
// one byte beat accepted per cycle while s_ready is high; its results enter
// the result queue at the same edge, so with the queue empty the first result
// shows in the cycle after its byte; a beat raising two results needs two free
// queue slots, the output side draining one per cycle sets the sustained rate
// synchronous active low reset: parser idle, queue empty, file length zero
// ----------------------------------------------------------------------------
`include "midi_file_chunk_parser_macros.svh"

module midi_file_chunk_parser
    import midi_fcp_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_first_byte,
    input  logic [7:0]  s_data_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic        m_file_format,
    output logic [14:0] m_ticks_per_quarter,
    output logic [15:0] m_track_index,
    output logic [31:0] m_data_offset,
    output logic [31:0] m_data_length,
    output logic [15:0] m_tracks_found,
    output logic [2:0]  m_status,
    output logic        m_last
);

    logic [31:0] file_length_reg;
    state_t      state_reg;
    state_t      state_next;
    push_t       push;
    result_t     m_res;
    logic        room;
    logic        accept;

    assign s_ready = room;
    assign accept  = s_valid && s_ready;

    midi_fcp_step u_step (
        .file_length (file_length_reg),
        .cur         (state_reg),
        .accept      (accept),
        .first_byte  (s_first_byte),
        .data_byte   (s_data_byte),
        .nxt         (state_next),
        .push        (push)
    );

    midi_fcp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_length_reg <= '0;
        end else if (cfg_wr_en) begin
            file_length_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase         <= PH_IDLE;
            state_reg.field_count   <= '0;
            state_reg.accumulator   <= '0;
            state_reg.position      <= '0;
            state_reg.skip_left     <= '0;
            state_reg.header_format <= 1'b0;
            state_reg.track_counter <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    assign m_kind              = m_res.kind;
    assign m_file_format       = m_res.file_format;
    assign m_ticks_per_quarter = m_res.ticks_per_quarter;
    assign m_track_index       = m_res.track_index;
    assign m_data_offset       = m_res.data_offset;
    assign m_data_length       = m_res.data_length;
    assign m_tracks_found      = m_res.tracks_found;
    assign m_status            = m_res.status;
    assign m_last              = m_res.last;

    `MFCP_ASSERT_NEXT(a_first_wakes, accept && s_first_byte,
        state_reg.phase != PH_IDLE, "first byte left parser idle")
    `MFCP_ASSERT_SAME(a_quiet_after_end,
        accept && !s_first_byte && (state_reg.phase == PH_DONE || state_reg.phase == PH_IDLE),
        push.count == 2'd0, "result raised outside a file")
    `MFCP_ASSERT_NEXT(a_track_count,
        accept && push.count != 2'd0 && push.res0.kind == KIND_TRACK,
        state_reg.track_counter == $past(state_reg.track_counter) + 16'd1,
        "track result without counter step")

endmodule

/* design/midi_fcp_step.sv */
// ----------------------------------------------------------------------------
// midi fcp step
// next parser state and the results raised by one accepted beat
// ----------------------------------------------------------------------------
module midi_fcp_step
    import midi_fcp_pkg::*;
(
    input  logic [31:0] file_length,
    input  state_t      cur,
    input  logic        accept,
    input  logic        first_byte,
    input  logic [7:0]  data_byte,
    output state_t      nxt,
    output push_t       push
);

    always_comb begin
        state_t      st;
        logic        consume;
        logic        fin;
        status_t     fin_st;
        logic        hdr;
        logic        trk;
        logic        beg;
        phase_t      beg_phase;
        logic [31:0] beg_need;
        logic        walk;
        logic        fdone;
        logic [31:0] acc_n;
        logic [31:0] pos_n;
        logic [31:0] rem;
        logic [15:0] w;
        logic [12:0] smpte_ticks;
        result_t     r_a;
        result_t     r_fin;

        st          = cur;
        consume     = 1'b0;
        fin         = 1'b0;
        fin_st      = STATUS_OK;
        hdr         = 1'b0;
        trk         = 1'b0;
        beg         = 1'b0;
        beg_phase   = PH_IDLE;
        beg_need    = NEED_LONG;
        walk        = 1'b0;
        fdone       = 1'b0;
        r_a         = '0;
        r_fin       = '0;
        push        = '0;

        if (accept) begin
            if (first_byte) begin
                st.field_count   = 2'd0;
                st.accumulator   = '0;
                st.position      = '0;
                st.skip_left     = '0;
                st.header_format = 1'b0;
                st.track_counter = '0;
                st.phase         = PH_HDR_ID;
                if (file_length < MIN_FILE_LEN) begin
                    fin    = 1'b1;
                    fin_st = STATUS_PAST_END;
                end else begin
                    consume = 1'b1;
                end
            end else if (st.phase != PH_IDLE && st.phase != PH_DONE) begin
                consume = 1'b1;
            end
        end

        acc_n = {st.accumulator[23:0], data_byte};
        pos_n = st.position + 32'd1;
        rem   = (pos_n <= file_length) ? (file_length - pos_n) : '0;
        w     = acc_n[15:0];

        smpte_ticks = 13'(smpte_fps(w[15:8]) * w[7:0]);

        r_a.kind          = KIND_HEADER;
        r_a.file_format   = st.header_format;
        r_a.ticks_per_quarter = w[SMPTE_BIT] ? 15'(smpte_ticks) : w[14:0];

        if (consume) begin
            st.accumulator = acc_n;
            st.position    = pos_n;
            if (st.phase == PH_SKIP) begin
                st.skip_left = st.skip_left - 32'd1;
                if (st.skip_left == '0) begin
                    walk = 1'b1;
                end
            end else begin
                if (st.phase == PH_FMT || st.phase == PH_NTRK || st.phase == PH_DIV) begin
                    fdone = (st.field_count != 2'd0);
                end else begin
                    fdone = (st.field_count == 2'd3);
                end
                if (fdone) begin
                    st.field_count = 2'd0;
                    unique case (st.phase)
                        PH_HDR_ID: begin
                            if (acc_n == ID_HEADER) begin
                                beg       = 1'b1;
                                beg_phase = PH_HDR_LEN;
                                beg_need  = NEED_LONG;
                            end else begin
                                walk = 1'b1;
                            end
                        end
                        PH_HDR_LEN: begin
                            if (acc_n != HDR_LEN) begin
                                fin    = 1'b1;
                                fin_st = STATUS_BAD_LEN;
                            end else begin
                                beg       = 1'b1;
                                beg_phase = PH_FMT;
                                beg_need  = NEED_SHORT;
                            end
                        end
                        PH_FMT: begin
                            if (w > 16'd1) begin
                                fin    = 1'b1;
                                fin_st = STATUS_BAD_FMT;
                            end else begin
                                st.header_format = w[0];
                                beg       = 1'b1;
                                beg_phase = PH_NTRK;
                                beg_need  = NEED_SHORT;
                            end
                        end
                        PH_NTRK: begin
                            if (!st.header_format && w != 16'd1) begin
                                fin    = 1'b1;
                                fin_st = STATUS_BAD_NTRK;
                            end else begin
                                beg       = 1'b1;
                                beg_phase = PH_DIV;
                                beg_need  = NEED_SHORT;
                            end
                        end
                        PH_DIV: begin
                            hdr  = 1'b1;
                            walk = 1'b1;
                        end
                        PH_CHUNK_ID: begin
                            if (acc_n == ID_TRACK) begin
                                beg       = 1'b1;
                                beg_phase = PH_CHUNK_LEN;
                                beg_need  = NEED_LONG;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        PH_CHUNK_LEN: begin
                            if (acc_n >= MIN_CHUNK_LEN && acc_n <= rem) begin
                                trk             = 1'b1;
                                r_a             = '0;
                                r_a.kind        = KIND_TRACK;
                                r_a.track_index = st.track_counter;
                                r_a.data_offset = pos_n;
                                r_a.data_length = acc_n;
                                st.track_counter = st.track_counter + 16'd1;
                                st.skip_left     = acc_n;
                                st.phase         = PH_SKIP;
                            end else begin
                                walk = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    st.field_count = st.field_count + 2'd1;
                end
            end

            if (beg) begin
                st.field_count = 2'd0;
                if (rem < beg_need) begin
                    fin    = 1'b1;
                    fin_st = STATUS_PAST_END;
                end else begin
                    st.phase = beg_phase;
                end
            end
            if (walk) begin
                st.field_count = 2'd0;
                if (rem > WALK_MIN_LEFT) begin
                    st.phase = PH_CHUNK_ID;
                end else begin
                    fin = 1'b1;
                end
            end
        end

        if (fin) begin
            st.phase = PH_DONE;
        end

        r_fin.kind         = KIND_END;
        r_fin.tracks_found = st.track_counter;
        r_fin.status       = fin_st;
        r_fin.last         = 1'b1;

        // header or track result goes out ahead of the end result
        if (hdr || trk) begin
            push.res0 = r_a;
            if (fin) begin
                push.count = 2'd2;
                push.res1  = r_fin;
            end else begin
                push.count     = 2'd1;
                push.res0.last = 1'b1;
            end
        end else if (fin) begin
            push.count = 2'd1;
            push.res0  = r_fin;
        end

        nxt = st;
    end

endmodule

/* design/midi_fcp_fifo.sv */
// ----------------------------------------------------------------------------
// midi fcp result queue
// small queue taking up to two results a cycle and giving one while m_ready is high
// ----------------------------------------------------------------------------
`include "midi_file_chunk_parser_macros.svh"

module midi_fcp_fifo
    import midi_fcp_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [IDX_W-1:0] idx_t;

    result_t           mem [DEPTH];
    idx_t              wr_ptr_reg;
    idx_t              wr_ptr_next;
    idx_t              rd_ptr_reg;
    idx_t              rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    idx_t              wr1;
    idx_t              wr2;
    logic              pop;

    function automatic idx_t inc(input idx_t p);
        return (p == IDX_W'(DEPTH - 1)) ? '0 : idx_t'(p + 1'b1);
    endfunction

    assign wr1     = inc(wr_ptr_reg);
    assign wr2     = inc(wr1);
    assign m_valid = (count_reg != '0);
    assign pop     = m_valid && m_ready;
    assign m_res   = mem[rd_ptr_reg];
    // two free slots so a beat never loses its second result
    assign room    = (count_reg <= CNT_W'(DEPTH - 2));

    always_comb begin
        rd_ptr_next = pop ? inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
        case (push.count)
            2'd1:    wr_ptr_next = wr1;
            2'd2:    wr_ptr_next = wr2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            mem[wr1] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `MFCP_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "result queue overfilled")
    `MFCP_ASSERT_NEXT(a_pair_fill, push.count == 2'd2 && !pop,
        count_reg == $past(count_reg) + CNT_W'(2), "pair push not counted")
    `MFCP_ASSERT_NEXT(a_drain, pop && push.count == 2'd0,
        count_reg == $past(count_reg) - CNT_W'(1), "pop not counted")

endmodule
